@@ hdl/stis_pkg.sv @@
package stis_pkg;

    localparam int DATA_W          = 32;
    localparam int IDX_W           = 6;
    localparam int COUNT_W         = 7;
    localparam int DEF_TABLE_DEPTH = 64;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd50;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // stream payload layout
    localparam int S_TDATA_W    = 72;
    localparam int S_INDEX_LSB  = 0;
    localparam int S_VALUE_LSB  = S_INDEX_LSB + IDX_W;
    localparam int S_KEY_LSB    = S_VALUE_LSB + DATA_W;
    localparam int S_PAD_W      = S_TDATA_W - (S_KEY_LSB + DATA_W);
    localparam int M_TDATA_W    = 8;
    localparam int M_PAD_W      = M_TDATA_W - IDX_W;

endpackage

@@ hdl/stis_ram.sv @@
module stis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/stis_muldiv.sv @@
// Shift-add multiply followed by restoring divide, both on one adder.
// quotient = floor(opd_a * opd_m / divisor), valid with done.
// Requires opd_a <= divisor and divisor != 0, so the quotient fits MW bits.
module stis_muldiv #(
    parameter int MW = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [stis_pkg::DATA_W-1:0] opd_a,
    input  logic [MW-1:0]             opd_m,
    input  logic [stis_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [MW-1:0]             quotient
);

    localparam int DW    = stis_pkg::DATA_W;
    localparam int CNT_W = (MW > 1) ? $clog2(MW) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MW - 1);
    localparam logic PH_MUL = 1'b0;
    localparam logic PH_DIV = 1'b1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW:0]      acc_reg, acc_next;
    logic [MW-1:0]    q_reg, q_next;
    logic [DW-1:0]    d_reg, d_next;
    logic [DW-1:0]    span_reg, span_next;

    logic [DW:0]      add_a;
    logic [DW:0]      add_b;
    logic             add_cin;
    logic [DW+1:0]    sum;
    logic [MW:0]      mul_shift;
    logic [MW:0]      div_shift;
    logic             geq;

    always_comb
    begin
        if (phase_reg == PH_MUL)
        begin
            add_a   = acc_reg;
            add_b   = q_reg[0] ? {1'b0, d_reg} : '0;
            add_cin = 1'b0;
        end
        else
        begin
            add_a   = {acc_reg[DW-1:0], q_reg[MW-1]};
            add_b   = ~{1'b0, span_reg};
            add_cin = 1'b1;
        end
        sum       = {1'b0, add_a} + {1'b0, add_b} + (DW+2)'(add_cin);
        geq       = sum[DW+1];
        mul_shift = {sum[0], q_reg};
        div_shift = {q_reg, geq};
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        span_next  = span_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = PH_MUL;
            cnt_next   = '0;
            acc_next   = '0;
            q_next     = opd_m;
            d_next     = opd_a;
            span_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (phase_reg == PH_MUL)
            begin
                // shift the running product right, one multiplier bit a step
                acc_next = {1'b0, sum[DW:1]};
                q_next   = mul_shift[MW:1];
            end
            else
            begin
                // keep the difference only when the trial subtract did not borrow
                acc_next = geq ? sum[DW:0] : add_a;
                q_next   = div_shift[MW-1:0];
            end
            if (cnt_reg == LAST_STEP)
            begin
                cnt_next = '0;
                if (phase_reg == PH_MUL)
                begin
                    phase_next = PH_DIV;
                end
                else
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_MUL;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        span_reg <= span_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ hdl/sorted_table_interpolation_search_core.sv @@
// Interpolation search over a table of signed 32-bit values kept in ascending
// order. A write item (tuser = 0) stores one entry and gives no result; a search
// item (tuser = 1) returns found and match_index. Each probe reads the two end
// values and the probe value from the table RAM and, when the end values differ,
// computes the probe position with a shift-add multiply and a restoring divide on
// one shared 34-bit adder. The adder steps take most of each probe; a search takes
// one to a few probes on evenly spread data. The input is not ready while a search
// runs; a finished result waits in the output register without blocking the next
// item. entry_count is written through the cfg port; the user must write it only
// while idle, which the block itself does not enforce. Counts above TABLE_DEPTH
// are clamped.
module sorted_table_interpolation_search_core #(
    parameter int TABLE_DEPTH = stis_pkg::DEF_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index, entry_value, search_key, zero pad
    input  logic [stis_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // match_index, zero pad
    output logic [stis_pkg::M_TDATA_W-1:0] m_tdata,
    // found
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [stis_pkg::COUNT_W-1:0]   cfg_data
);

    localparam int DW = stis_pkg::DATA_W;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = AW + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RD_L  = 3'd2;
    localparam logic [2:0] S_RD_R  = 3'd3;
    localparam logic [2:0] S_CALC  = 3'd4;
    localparam logic [2:0] S_PROBE = 3'd5;
    localparam logic [2:0] S_RD_P  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                   state_reg, state_next;
    logic [stis_pkg::COUNT_W-1:0] count_reg;
    logic signed [DW-1:0]         key_reg, key_next;
    logic signed [PW-1:0]         lo_reg, lo_next;
    logic signed [PW-1:0]         hi_reg, hi_next;
    logic signed [DW-1:0]         vl_reg, vl_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic                         res_found_reg, res_found_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_found_reg, out_found_next;
    logic [stis_pkg::IDX_W-1:0]   out_index_reg, out_index_next;

    logic                         in_xfer;
    logic [stis_pkg::IDX_W-1:0]   in_index;
    logic [DW-1:0]                in_value;
    logic [DW-1:0]                in_key;
    logic [31:0]                  wr_idx32;
    logic [31:0]                  cnt32;
    logic [31:0]                  n32;
    logic [31:0]                  pos32;
    logic                         wr_en;
    logic [AW-1:0]                rd_addr;
    logic [DW-1:0]                rd_data;
    logic signed [DW-1:0]         rd_value;
    logic signed [PW-1:0]         pos_s;
    logic signed [PW-1:0]         range_s;
    logic [DW-1:0]                span;
    logic [DW-1:0]                key_off;
    logic                         unit_start;
    logic                         unit_done;
    logic [AW-1:0]                unit_q;

    assign in_xfer  = s_tvalid && s_tready;
    assign in_index = s_tdata[stis_pkg::S_INDEX_LSB +: stis_pkg::IDX_W];
    assign in_value = s_tdata[stis_pkg::S_VALUE_LSB +: DW];
    assign in_key   = s_tdata[stis_pkg::S_KEY_LSB +: DW];
    assign wr_idx32 = 32'(in_index);
    assign wr_en    = in_xfer && (s_tuser == stis_pkg::CMD_WRITE)
                      && (wr_idx32 < 32'(TABLE_DEPTH));

    assign cnt32    = 32'(count_reg);
    assign n32      = (cnt32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt32;

    assign rd_value = $signed(rd_data);
    assign span     = rd_data - vl_reg;
    assign key_off  = key_reg - vl_reg;
    assign range_s  = hi_reg - lo_reg;
    assign pos_s    = $signed({2'b00, pos_reg});
    assign pos32    = 32'(pos_reg);

    always_comb
    begin
        case (state_reg)
            S_CHECK: rd_addr = lo_reg[AW-1:0];
            S_RD_L:  rd_addr = hi_reg[AW-1:0];
            default: rd_addr = pos_reg;
        endcase
    end

    stis_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx32[AW-1:0]),
        .wr_data (in_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stis_muldiv #(
        .MW (AW)
    ) u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (unit_start),
        .opd_a    (key_off),
        .opd_m    (range_s[AW-1:0]),
        .divisor  (span),
        .done     (unit_done),
        .quotient (unit_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        vl_next        = vl_reg;
        pos_next       = pos_reg;
        res_found_next = res_found_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;
        unit_start     = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (s_tuser == stis_pkg::CMD_SEARCH))
                begin
                    key_next       = $signed(in_key);
                    lo_next        = '0;
                    hi_next        = $signed(PW'(n32 - 32'd1));
                    pos_next       = '0;
                    res_found_next = 1'b0;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (lo_reg > hi_reg)
                begin
                    pos_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RD_L;
                end
            end
            S_RD_L:
            begin
                vl_next    = rd_value;
                state_next = S_RD_R;
            end
            S_RD_R:
            begin
                if ((key_reg < vl_reg) || (key_reg > rd_value))
                begin
                    pos_next   = '0;
                    state_next = S_DONE;
                end
                else if (span == '0)
                begin
                    // equal end values: probe the left end
                    pos_next   = lo_reg[AW-1:0];
                    state_next = S_PROBE;
                end
                else
                begin
                    unit_start = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (unit_done)
                begin
                    pos_next   = lo_reg[AW-1:0] + unit_q;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = S_RD_P;
            end
            S_RD_P:
            begin
                if (rd_value == key_reg)
                begin
                    res_found_next = 1'b1;
                    state_next     = S_DONE;
                end
                else if (rd_value < key_reg)
                begin
                    lo_next    = pos_s + PW'(1);
                    state_next = S_CHECK;
                end
                else
                begin
                    hi_next    = pos_s - PW'(1);
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_index_next = res_found_reg ? pos32[stis_pkg::IDX_W-1:0] : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= stis_pkg::COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        vl_reg        <= vl_next;
        pos_reg       <= pos_next;
        res_found_reg <= res_found_next;
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_found_reg;
    assign m_tdata   = {{stis_pkg::M_PAD_W{1'b0}}, out_index_reg};

endmodule

@@ hdl/stis_checker.sv @@
module stis_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [stis_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    // a write transfer never produces a result
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == stis_pkg::CMD_WRITE)) |=> !$rose(m_tvalid))
        else $error("result appeared after a table write");

    // a search occupies the block, so the input drops ready right after it
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == stis_pkg::CMD_SEARCH)) |=> !s_tready)
        else $error("input still ready after a search transfer");

    // a miss reports index zero
    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss with nonzero match index");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind sorted_table_interpolation_search_core stis_checker u_stis_checker (.*);

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = stis_pkg::DEF_TABLE_DEPTH;
    localparam int IDX_W        = stis_pkg::IDX_W;
    localparam int DATA_W       = stis_pkg::DATA_W;
    localparam int COUNT_W      = stis_pkg::COUNT_W;
    localparam int S_TDATA_W    = stis_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = stis_pkg::M_TDATA_W;
    localparam int S_PAD_W      = stis_pkg::S_PAD_W;
    localparam int QUIET_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 840;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } lookup_t;

    localparam lookup_t MISS = '0;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SEARCH, ROW_COUNT} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [31:0]      arg;
        bit               typed;
        lookup_t          res;
    } row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data  = '0;

    logic signed [DATA_W-1:0] shadow_table [DEPTH];
    logic [COUNT_W-1:0]       count_setting = stis_pkg::COUNT_RESET;
    lookup_t                  pending_lookups [$];

    int  sent_searches = 0;
    int  results_seen  = 0;
    int  items_sent    = 0;
    int  writes_sent   = 0;
    int  hits_expected = 0;
    int  settings_done = 0;
    int  errors        = 0;
    int  mismatches    = 0;
    bit  calm          = 1'b0;

    // Directed stimulus; typed results follow from the table contents by inspection.
    row_t plan [] = '{
        '{ROW_SEARCH, 6'd0,  32'd49000,    1'b1, '{1'b1, 6'd49}},
        '{ROW_SEARCH, 6'd0,  32'd50000,    1'b1, MISS},
        '{ROW_SEARCH, 6'd0,  32'hFFFFFFFF, 1'b1, MISS},
        '{ROW_SEARCH, 6'd0,  32'd12345,    1'b0, MISS},
        '{ROW_COUNT,  6'd0,  32'd64,       1'b0, MISS},
        '{ROW_WRITE,  6'd0,  32'h80000000, 1'b0, MISS},
        '{ROW_WRITE,  6'd63, 32'h7FFFFFFF, 1'b0, MISS},
        '{ROW_SEARCH, 6'd0,  32'h80000000, 1'b1, '{1'b1, 6'd0}},
        '{ROW_SEARCH, 6'd0,  32'h7FFFFFFF, 1'b1, '{1'b1, 6'd63}},
        '{ROW_SEARCH, 6'd0,  32'd1000,     1'b0, MISS},
        '{ROW_SEARCH, 6'd0,  32'h7FFFFFFE, 1'b0, MISS},
        '{ROW_COUNT,  6'd0,  32'd0,        1'b0, MISS},
        '{ROW_SEARCH, 6'd0,  32'd1000,     1'b1, MISS},
        '{ROW_COUNT,  6'd0,  32'd127,      1'b0, MISS},
        '{ROW_SEARCH, 6'd0,  32'h7FFFFFFF, 1'b1, '{1'b1, 6'd63}},
        '{ROW_COUNT,  6'd0,  32'd1,        1'b0, MISS},
        '{ROW_SEARCH, 6'd0,  32'h80000000, 1'b1, '{1'b1, 6'd0}},
        '{ROW_SEARCH, 6'd0,  32'd1000,     1'b1, MISS},
        '{ROW_COUNT,  6'd0,  32'd4,        1'b0, MISS},
        '{ROW_WRITE,  6'd1,  32'd5,        1'b0, MISS},
        '{ROW_WRITE,  6'd2,  32'd5,        1'b0, MISS},
        '{ROW_WRITE,  6'd3,  32'd5,        1'b0, MISS},
        '{ROW_WRITE,  6'd0,  32'd5,        1'b0, MISS},
        '{ROW_SEARCH, 6'd0,  32'd5,        1'b1, '{1'b1, 6'd0}},
        '{ROW_SEARCH, 6'd0,  32'd6,        1'b1, MISS},
        '{ROW_WRITE,  6'd2,  32'hFFFFFFF9, 1'b0, MISS},
        '{ROW_SEARCH, 6'd0,  32'd5,        1'b0, MISS},
        '{ROW_SEARCH, 6'd0,  32'hFFFFFFF9, 1'b0, MISS}
    };

    sorted_table_interpolation_search_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic lookup_t lookup_key(logic signed [DATA_W-1:0] key_bits);
        longint  key;
        longint  lo;
        longint  hi;
        longint  vl;
        longint  vr;
        longint  pos;
        longint  vp;
        lookup_t res;
        res = MISS;
        key = longint'(key_bits);
        lo  = 0;
        hi  = ((count_setting > DEPTH) ? DEPTH : count_setting) - 1;
        while (lo <= hi)
        begin
            vl = longint'(shadow_table[lo]);
            vr = longint'(shadow_table[hi]);
            if (key < vl || key > vr)
                break;
            // equal end values: probe the left end itself
            if (vr == vl)
                pos = lo;
            else
                pos = lo + ((key - vl) * (hi - lo)) / (vr - vl);
            vp = longint'(shadow_table[pos]);
            if (vp == key)
            begin
                res.found       = 1'b1;
                res.match_index = pos[IDX_W-1:0];
                return res;
            end
            if (vp < key)
                lo = pos + 1;
            else
                hi = pos - 1;
        end
        return res;
    endfunction

    task automatic send_item(logic cmd, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value,
                             logic [DATA_W-1:0] key, bit typed, lookup_t typed_res);
        lookup_t res;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{S_PAD_W{1'b0}}, key, value, idx};
        do @(posedge clk); while (!s_tready);
        // transfer taken at this edge: update the shadow state in order
        items_sent++;
        if (cmd == stis_pkg::CMD_WRITE)
        begin
            shadow_table[idx] = value;
            writes_sent++;
        end
        else
        begin
            res = typed ? typed_res : lookup_key(key);
            pending_lookups.push_back(res);
            sent_searches++;
            if (res.found)
                hits_expected++;
        end
    endtask

    // Hold the sender until every search has answered, then let a write settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (results_seen != sent_searches) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_entry_count(logic [COUNT_W-1:0] count);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_setting = count;
        settings_done++;
    endtask

    initial
    begin : sink_pacing
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 19) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        lookup_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_lookups.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected result transfer: found=%0d index=%0d",
                             m_tuser, m_tdata[IDX_W-1:0]);
                mismatches++;
            end
            else
            begin
                exp_res = pending_lookups.pop_front();
                if (m_tuser !== exp_res.found || m_tdata[IDX_W-1:0] !== exp_res.match_index)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display({"search result mismatch: expected found=%0d index=%0d,",
                                  " got found=%0d index=%0d"},
                                 exp_res.found, exp_res.match_index,
                                 m_tuser, m_tdata[IDX_W-1:0]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int          random_start;
        int          cnt;
        int          n;
        int          mode;
        int          j;
        longint      v;
        int unsigned step_max;
        logic [31:0] key;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // ascending fill of the whole table under the reset count
        for (int i = 0; i < DEPTH; i++)
            send_item(stis_pkg::CMD_WRITE, i[IDX_W-1:0], i * 1000, $urandom, 1'b0, MISS);

        foreach (plan[r])
        begin
            case (plan[r].kind)
                ROW_COUNT:
                begin
                    wait_idle();
                    write_entry_count(plan[r].arg[COUNT_W-1:0]);
                end
                ROW_WRITE:
                    send_item(stis_pkg::CMD_WRITE, plan[r].idx, plan[r].arg, $urandom,
                              1'b0, MISS);
                default:
                    send_item(stis_pkg::CMD_SEARCH, IDX_W'($urandom), $urandom, plan[r].arg,
                              plan[r].typed, plan[r].res);
            endcase
        end

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       cnt = 1;
                1:       cnt = 64;
                2:       cnt = 0;
                3:       cnt = $urandom_range(65, 127);
                default: cnt = $urandom_range(2, 63);
            endcase
            wait_idle();
            write_entry_count(cnt[COUNT_W-1:0]);
            n = (cnt > DEPTH) ? DEPTH : cnt;

            // sorted fill: dense with repeats, full-range spread, or mid-range steps
            mode = $urandom_range(0, 2);
            if (mode == 0)
            begin
                v        = longint'($urandom_range(0, 2000)) - 1000;
                step_max = 3;
            end
            else if (mode == 1)
            begin
                v        = longint'($urandom_range(0, 1 << 20)) - 64'sd2147483648;
                step_max = 32'hFFFF_FFFF / ((n > 0) ? n : 1);
            end
            else
            begin
                v        = longint'($signed($urandom));
                step_max = 100000;
            end
            for (int i = 0; i < n; i++)
            begin
                if (v > 64'sd2147483647)
                    v = 64'sd2147483647;
                send_item(stis_pkg::CMD_WRITE, i[IDX_W-1:0], v[31:0], $urandom, 1'b0, MISS);
                v = v + longint'($urandom_range((mode == 2) ? 1 : 0, step_max));
            end

            repeat ($urandom_range(15, 40))
            begin
                if (items_sent - random_start >= RANDOM_ITEMS - 100)
                    calm = 1'b1;
                if ($urandom_range(0, 19) == 0)
                begin
                    // stray write, may break the ordering
                    send_item(stis_pkg::CMD_WRITE, IDX_W'($urandom), $urandom, $urandom,
                              1'b0, MISS);
                end
                else
                begin
                    if (n == 0)
                        key = $urandom;
                    else
                    begin
                        j = $urandom_range(0, n - 1);
                        case ($urandom_range(0, 9))
                            6, 7:    key = shadow_table[j] + $urandom_range(1, 3);
                            8:       key = $urandom_range(0, 1) ? shadow_table[0] - 1
                                                                : shadow_table[n - 1] + 1;
                            9:       key = $urandom;
                            default: key = shadow_table[j];
                        endcase
                    end
                    send_item(stis_pkg::CMD_SEARCH, IDX_W'($urandom), $urandom, key,
                              1'b0, MISS);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (results_seen != sent_searches) @(posedge clk);
        repeat (40) @(posedge clk);

        if (pending_lookups.size() != 0)
        begin
            errors++;
            $display("%0d search results never arrived", pending_lookups.size());
        end
        if (mismatches > 10)
            $display("%0d further mismatches not shown", mismatches - 10);
        $display("Run covered %0d table writes and %0d searches (%0d expected hits)",
                 writes_sent, sent_searches, hits_expected);
        $display("across %0d entry_count settings, including 0, 1, 64 and saturated counts",
                 settings_done);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/stis_pkg.sv
hdl/stis_ram.sv
hdl/stis_muldiv.sv
hdl/sorted_table_interpolation_search_core.sv
hdl/stis_checker.sv
tb/testbench.sv
